// ===== sv/bao_pkg.sv =====
// Shared types, constants and arithmetic helpers for the binomial option pricer.
package bao_pkg;

	localparam int MAX_STEPS_DEF = 1023;
	localparam logic [31:0] Q30_ONE = 32'h4000_0000;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_PUT_MODE          = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEPS_IN_USE      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PROB_UP           = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_UP_FACTOR         = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN_FACTOR       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_GROWTH      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TERMINAL_DISCOUNT = 3'd6;

	typedef struct packed {
		logic [31:0] spot_price;
		logic [31:0] strike;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] amer_val;
		logic [31:0] euro_val;
	} out_beat_t;

	typedef struct packed {
		logic        put_mode;
		logic [9:0]  steps_in_use;
		logic [30:0] prob_up;
		logic [31:0] up_factor;
		logic [31:0] down_factor;
		logic [31:0] level_growth;
		logic [31:0] terminal_discount;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_IDLE,
		OP_WR_SPOT,
		OP_MUL_UP,
		OP_WR_UP,
		OP_MUL_DN,
		OP_WR_DN,
		OP_WR_G0,
		OP_MUL_G,
		OP_WR_G,
		OP_RD,
		OP_LEAF_MUL,
		OP_LEAF_WR,
		OP_R1,
		OP_R2,
		OP_R3,
		OP_R4,
		OP_R5,
		OP_R6,
		OP_PUB
	} op_t;

	// (x*f)>>30, saturated to 32 bits
	function automatic logic [31:0] sat_q30(input logic [63:0] prod);
		logic [33:0] r;
		r = prod[63:30];
		return (r[33:32] != 2'b00) ? 32'hFFFF_FFFF : r[31:0];
	endfunction

	function automatic logic [31:0] payoff(input logic [31:0] price, input logic [31:0] k,
			input logic put);
		logic [31:0] res;
		if (put) begin
			res = (k > price) ? k - price : 32'd0;
		end else begin
			res = (price > k) ? price - k : 32'd0;
		end
		return res;
	endfunction

endpackage

// ===== sv/bao_dp.sv =====
// Datapath: price, growth and node memories, one shared multiplier, roll-back arithmetic.
module bao_dp import bao_pkg::*; #(
	parameter int MAX_STEPS = MAX_STEPS_DEF,
	parameter int IDX_W = $clog2(MAX_STEPS + 1),
	parameter int PT_W = $clog2(2 * MAX_STEPS + 1)
) (
	input  logic             clk,
	input  logic             take,
	input  in_beat_t         in_data,
	input  cfg_t             cfg,
	input  op_t              op,
	input  logic [IDX_W-1:0] node_addr,
	input  logic [PT_W-1:0]  pt_addr,
	input  logic [IDX_W-1:0] gt_addr,
	output out_beat_t        out_data
);

	localparam int PT_DEPTH = 2 * MAX_STEPS + 1;
	localparam int ND_DEPTH = MAX_STEPS + 1;

	logic [31:0] pt_mem [PT_DEPTH];
	logic [31:0] gt_mem [ND_DEPTH];
	logic [31:0] euro_mem [ND_DEPTH];
	logic [31:0] amer_mem [ND_DEPTH];

	logic [31:0] spot_q, k_q, up_q, dn_q, g_q;
	logic [31:0] pt_rd_q, g_rd_q, e0_q, e1_q, a0_q, a1_q;
	logic [31:0] pay_q, e_q, av_q;
	logic [63:0] prod_q, acc_q;
	out_beat_t   res_q, out_q;

	logic [30:0] p, q;
	logic [31:0] mul_a, mul_b, sat_v, roll_v, amax;
	logic [63:0] sum_v;
	logic [IDX_W-1:0] node_next;

	assign p = (cfg.prob_up > Q30_ONE[30:0]) ? Q30_ONE[30:0] : cfg.prob_up;
	assign q = Q30_ONE[30:0] - p;
	assign sat_v = sat_q30(prod_q);
	assign sum_v = acc_q + prod_q;
	assign roll_v = sum_v[61:30];
	assign amax = (sat_v > av_q) ? sat_v : av_q;
	assign node_next = node_addr + IDX_W'(1);
	assign out_data = out_q;

	always_comb begin
		unique case (op)
			OP_MUL_UP: begin
				mul_a = up_q;
				mul_b = cfg.up_factor;
			end
			OP_MUL_DN: begin
				mul_a = dn_q;
				mul_b = cfg.down_factor;
			end
			OP_MUL_G: begin
				mul_a = g_q;
				mul_b = cfg.level_growth;
			end
			OP_LEAF_MUL: begin
				mul_a = payoff(pt_rd_q, k_q, cfg.put_mode);
				mul_b = cfg.terminal_discount;
			end
			OP_R1: begin
				mul_a = {1'b0, p};
				mul_b = e0_q;
			end
			OP_R2: begin
				mul_a = {1'b0, q};
				mul_b = e1_q;
			end
			OP_R3: begin
				mul_a = {1'b0, p};
				mul_b = a0_q;
			end
			OP_R4: begin
				mul_a = {1'b0, q};
				mul_b = a1_q;
			end
			OP_R5: begin
				mul_a = pay_q;
				mul_b = g_rd_q;
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		if (take) begin
			spot_q <= in_data.spot_price;
			k_q <= in_data.strike;
		end
		unique case (op)
			OP_WR_SPOT: begin
				pt_mem[pt_addr] <= spot_q;
				up_q <= spot_q;
				dn_q <= spot_q;
			end
			OP_WR_UP: begin
				pt_mem[pt_addr] <= sat_v;
				up_q <= sat_v;
			end
			OP_WR_DN: begin
				pt_mem[pt_addr] <= sat_v;
				dn_q <= sat_v;
			end
			OP_WR_G0: begin
				gt_mem[gt_addr] <= Q30_ONE;
				g_q <= Q30_ONE;
			end
			OP_WR_G: begin
				gt_mem[gt_addr] <= sat_v;
				g_q <= sat_v;
			end
			OP_RD: begin
				pt_rd_q <= pt_mem[pt_addr];
				g_rd_q <= gt_mem[gt_addr];
				e0_q <= euro_mem[node_addr];
				e1_q <= euro_mem[node_next];
				a0_q <= amer_mem[node_addr];
				a1_q <= amer_mem[node_next];
			end
			OP_LEAF_WR: begin
				euro_mem[node_addr] <= sat_v;
				amer_mem[node_addr] <= sat_v;
			end
			OP_R1: pay_q <= payoff(pt_rd_q, k_q, cfg.put_mode);
			OP_R2: acc_q <= prod_q;
			OP_R3: e_q <= roll_v;
			OP_R4: acc_q <= prod_q;
			OP_R5: av_q <= roll_v;
			OP_R6: begin
				euro_mem[node_addr] <= e_q;
				amer_mem[node_addr] <= amax;
				res_q <= '{amer_val: amax, euro_val: e_q};
			end
			OP_PUB: out_q <= res_q;
			default: ;
		endcase
	end

endmodule

// ===== sv/bao_ctrl.sv =====
// Controller: sequences table build, leaf seeding and tree roll-back; owns the handshakes.
module bao_ctrl import bao_pkg::*; #(
	parameter int MAX_STEPS = MAX_STEPS_DEF,
	parameter int IDX_W = $clog2(MAX_STEPS + 1),
	parameter int PT_W = $clog2(2 * MAX_STEPS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	input  logic [9:0]       steps_in_use,
	output logic             take,
	output op_t              op,
	output logic [IDX_W-1:0] node_addr,
	output logic [PT_W-1:0]  pt_addr,
	output logic [IDX_W-1:0] gt_addr
);

	typedef enum logic [4:0] {
		S_IDLE, S_WR_SPOT, S_MUP, S_WUP, S_MDN, S_WDN, S_WG0, S_MG, S_WG,
		S_LRD, S_LMUL, S_LWR, S_RRD, S_R1, S_R2, S_R3, S_R4, S_R5, S_R6, S_FIN
	} state_t;

	localparam logic [PT_W-1:0] MID = PT_W'(MAX_STEPS);

	state_t state_q;
	logic [IDX_W-1:0] i_q, j_q, n_q, n_clamp;
	logic out_valid_q;
	logic publish;
	logic [PT_W-1:0] lvl_addr;

	assign n_clamp = (steps_in_use == 10'd0) ? IDX_W'(1) :
		((int'(steps_in_use) > MAX_STEPS) ? IDX_W'(MAX_STEPS) : IDX_W'(steps_in_use));
	assign in_stall = (state_q != S_IDLE);
	assign take = in_valid && (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign publish = (state_q == S_FIN) && (!out_valid_q || !out_stall);
	assign lvl_addr = MID + PT_W'(j_q) - (PT_W'(i_q) << 1);
	assign node_addr = i_q;
	assign gt_addr = (state_q == S_WG0) ? IDX_W'(0) : ((state_q == S_WG) ? i_q : j_q);

	always_comb begin
		pt_addr = lvl_addr;
		unique case (state_q)
			S_WR_SPOT: pt_addr = MID;
			S_WUP:     pt_addr = MID + PT_W'(i_q);
			S_WDN:     pt_addr = MID - PT_W'(i_q);
			default:   pt_addr = lvl_addr;
		endcase
	end

	always_comb begin
		unique case (state_q)
			S_WR_SPOT: op = OP_WR_SPOT;
			S_MUP:     op = OP_MUL_UP;
			S_WUP:     op = OP_WR_UP;
			S_MDN:     op = OP_MUL_DN;
			S_WDN:     op = OP_WR_DN;
			S_WG0:     op = OP_WR_G0;
			S_MG:      op = OP_MUL_G;
			S_WG:      op = OP_WR_G;
			S_LRD:     op = OP_RD;
			S_LMUL:    op = OP_LEAF_MUL;
			S_LWR:     op = OP_LEAF_WR;
			S_RRD:     op = OP_RD;
			S_R1:      op = OP_R1;
			S_R2:      op = OP_R2;
			S_R3:      op = OP_R3;
			S_R4:      op = OP_R4;
			S_R5:      op = OP_R5;
			S_R6:      op = OP_R6;
			S_FIN:     op = publish ? OP_PUB : OP_IDLE;
			default:   op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			n_q <= '0;
		end else begin
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						n_q <= n_clamp;
						j_q <= n_clamp;
						i_q <= IDX_W'(1);
						state_q <= S_WR_SPOT;
					end
				end
				S_WR_SPOT: state_q <= S_MUP;
				S_MUP:     state_q <= S_WUP;
				S_WUP:     state_q <= S_MDN;
				S_MDN:     state_q <= S_WDN;
				S_WDN: begin
					if (i_q == n_q) begin
						state_q <= S_WG0;
					end else begin
						i_q <= i_q + IDX_W'(1);
						state_q <= S_MUP;
					end
				end
				S_WG0: begin
					i_q <= IDX_W'(1);
					state_q <= S_MG;
				end
				S_MG: state_q <= S_WG;
				S_WG: begin
					if (i_q == n_q) begin
						i_q <= '0;
						state_q <= S_LRD;
					end else begin
						i_q <= i_q + IDX_W'(1);
						state_q <= S_MG;
					end
				end
				S_LRD:  state_q <= S_LMUL;
				S_LMUL: state_q <= S_LWR;
				S_LWR: begin
					if (i_q == n_q) begin
						i_q <= '0;
						j_q <= n_q - IDX_W'(1);
						state_q <= S_RRD;
					end else begin
						i_q <= i_q + IDX_W'(1);
						state_q <= S_LRD;
					end
				end
				S_RRD: state_q <= S_R1;
				S_R1:  state_q <= S_R2;
				S_R2:  state_q <= S_R3;
				S_R3:  state_q <= S_R4;
				S_R4:  state_q <= S_R5;
				S_R5:  state_q <= S_R6;
				S_R6: begin
					if (i_q == j_q) begin
						if (j_q == '0) begin
							state_q <= S_FIN;
						end else begin
							j_q <= j_q - IDX_W'(1);
							i_q <= '0;
							state_q <= S_RRD;
						end
					end else begin
						i_q <= i_q + IDX_W'(1);
						state_q <= S_RRD;
					end
				end
				S_FIN: begin
					if (publish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== sv/binomial_american_option_pricer.sv =====
// Top level of the binomial tree American/European option pricer.
// Usage:
//  - Input channel (in_valid/in_stall/in_data) carries one beat per option:
//    spot price and strike, unsigned Q16.16. A beat is taken when in_valid is
//    high and in_stall is low; in_stall is high while an item is in work.
//  - Output channel (out_valid/out_stall/out_data) returns one beat per item:
//    American and European value, Q16.16. The result sits in an output
//    register, so a new item can be taken while that beat still waits.
//  - Each item works through the single shared 32x32 multiplier in turn:
//    the price and growth tables take a product and a write per entry,
//    each leaf a read, a discounted payoff product and a write, and each
//    interior node one node memory read, four roll-back products, one
//    intrinsic product and one write-back. The next input beat is taken
//    only after the result has moved to the output register.
//  - Configuration is written through cfg_we/cfg_index/cfg_data while idle;
//    unknown indexes are dropped.
//  - Reset clears the control state and loads the register defaults
//    (call, 1000 levels, p = 0.5, all factors 1.0); memories need no clearing.
//  - When the receiver stalls, the finished result holds; the next item
//    finishes its tree and then waits until the output register frees up.
module binomial_american_option_pricer import bao_pkg::*; #(
	parameter int MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_beat_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_beat_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int IDX_W = $clog2(MAX_STEPS + 1);
	localparam int PT_W = $clog2(2 * MAX_STEPS + 1);

	cfg_t cfg_q;
	logic take;
	op_t op;
	logic [IDX_W-1:0] node_addr, gt_addr;
	logic [PT_W-1:0] pt_addr;

	// configuration registers, to be written by the user only while idle; the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.put_mode <= 1'b0;
			cfg_q.steps_in_use <= 10'd1000;
			cfg_q.prob_up <= 31'h2000_0000;
			cfg_q.up_factor <= Q30_ONE;
			cfg_q.down_factor <= Q30_ONE;
			cfg_q.level_growth <= Q30_ONE;
			cfg_q.terminal_discount <= Q30_ONE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PUT_MODE:          cfg_q.put_mode <= cfg_data[0];
				CFG_STEPS_IN_USE:      cfg_q.steps_in_use <= cfg_data[9:0];
				CFG_PROB_UP:           cfg_q.prob_up <= cfg_data[30:0];
				CFG_UP_FACTOR:         cfg_q.up_factor <= cfg_data;
				CFG_DOWN_FACTOR:       cfg_q.down_factor <= cfg_data;
				CFG_LEVEL_GROWTH:      cfg_q.level_growth <= cfg_data;
				CFG_TERMINAL_DISCOUNT: cfg_q.terminal_discount <= cfg_data;
				default: ;
			endcase
		end
	end

	bao_ctrl #(
		.MAX_STEPS(MAX_STEPS),
		.IDX_W(IDX_W),
		.PT_W(PT_W)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.steps_in_use(cfg_q.steps_in_use),
		.take(take),
		.op(op),
		.node_addr(node_addr),
		.pt_addr(pt_addr),
		.gt_addr(gt_addr)
	);

	bao_dp #(
		.MAX_STEPS(MAX_STEPS),
		.IDX_W(IDX_W),
		.PT_W(PT_W)
	) u_dp (
		.clk(clk),
		.take(take),
		.in_data(in_data),
		.cfg(cfg_q),
		.op(op),
		.node_addr(node_addr),
		.pt_addr(pt_addr),
		.gt_addr(gt_addr),
		.out_data(out_data)
	);

endmodule

// ===== test/bao_checker.sv =====
// Checker for the binomial option pricer: watches both channels, predicts each result and compares.
module bao_checker import bao_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  in_beat_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  out_beat_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output int                   errors,
	output int                   pending,
	output int                   checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TOP = 1023;

	cfg_t      regs;
	out_beat_t option_values_q[$];

	function automatic logic [31:0] scale_q30(input logic [31:0] x, input logic [31:0] f);
		logic [63:0] prod;
		prod = {32'd0, x} * {32'd0, f};
		prod = prod >> 30;
		return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
	endfunction

	function automatic logic [31:0] exercise_gain(input logic [31:0] px, input logic [31:0] k,
			input logic put);
		if (put)
			return (k > px) ? k - px : 32'd0;
		return (px > k) ? px - k : 32'd0;
	endfunction

	function automatic out_beat_t price_option(input in_beat_t b, input cfg_t c);
		logic [31:0] px [0:2*TOP];
		logic [31:0] gr [0:TOP];
		logic [31:0] eu [0:TOP];
		logic [31:0] am [0:TOP];
		logic [31:0] p, q, av, iv;
		logic [63:0] e, a;
		int          n, i, j, idx;
		out_beat_t   r;
		n = c.steps_in_use;
		if (n < 1) n = 1;
		p = ({1'b0, c.prob_up} > Q30_ONE) ? Q30_ONE : {1'b0, c.prob_up};
		q = Q30_ONE - p;
		px[TOP] = b.spot_price;
		for (i = 1; i <= n; i++) begin
			px[TOP+i] = scale_q30(px[TOP+i-1], c.up_factor);
			px[TOP-i] = scale_q30(px[TOP-i+1], c.down_factor);
		end
		gr[0] = Q30_ONE;
		for (j = 1; j <= n; j++) gr[j] = scale_q30(gr[j-1], c.level_growth);
		for (i = 0; i <= n; i++) begin
			eu[i] = scale_q30(exercise_gain(px[TOP+n-2*i], b.strike, c.put_mode),
				c.terminal_discount);
			am[i] = eu[i];
		end
		for (j = n - 1; j >= 0; j--) begin
			for (i = 0; i <= j; i++) begin
				e = {32'd0, p} * {32'd0, eu[i]} + {32'd0, q} * {32'd0, eu[i+1]};
				a = {32'd0, p} * {32'd0, am[i]} + {32'd0, q} * {32'd0, am[i+1]};
				av = a[61:30];
				idx = TOP + j - 2 * i;
				iv = scale_q30(exercise_gain(px[idx], b.strike, c.put_mode), gr[j]);
				eu[i] = e[61:30];
				am[i] = (iv > av) ? iv : av;
			end
		end
		r.amer_val = am[0];
		r.euro_val = eu[0];
		return r;
	endfunction

	assign pending = option_values_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_beat_t exp_v;
		int        errs;
		errs = 0;
		if (!arst_n) begin
			regs.put_mode          <= 1'b0;
			regs.steps_in_use      <= 10'd1000;
			regs.prob_up           <= 31'd536870912;
			regs.up_factor         <= Q30_ONE;
			regs.down_factor       <= Q30_ONE;
			regs.level_growth      <= Q30_ONE;
			regs.terminal_discount <= Q30_ONE;
			errors  <= 0;
			checked <= 0;
			option_values_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PUT_MODE:          regs.put_mode          <= cfg_data[0];
					CFG_STEPS_IN_USE:      regs.steps_in_use      <= cfg_data[9:0];
					CFG_PROB_UP:           regs.prob_up           <= cfg_data[30:0];
					CFG_UP_FACTOR:         regs.up_factor         <= cfg_data;
					CFG_DOWN_FACTOR:       regs.down_factor       <= cfg_data;
					CFG_LEVEL_GROWTH:      regs.level_growth      <= cfg_data;
					CFG_TERMINAL_DISCOUNT: regs.terminal_discount <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				option_values_q.push_back(price_option(in_data, regs));
			if (out_valid && !out_stall) begin
				if (option_values_q.size() == 0) begin
					$error("result beat with nothing expected: %h", out_data);
					errs++;
				end else begin
					exp_v = option_values_q.pop_front();
					checked <= checked + 1;
					if (out_data.amer_val !== exp_v.amer_val) begin
						$error("amer_val expected %h actual %h",
							exp_v.amer_val, out_data.amer_val);
						errs++;
					end
					if (out_data.euro_val !== exp_v.euro_val) begin
						$error("euro_val expected %h actual %h",
							exp_v.euro_val, out_data.euro_val);
						errs++;
					end
				end
			end
			if (errs != 0)
				errors <= errors + errs;
		end
	end
endmodule

// ===== test/tb.sv =====
// Testbench top for the binomial option pricer: stimulus, stall patterns and the verdict.
module tb;
	import bao_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// Watchdog limit; the longest correct item (1023 levels) runs with no beat moving.
	localparam int QUIET_LIMIT = 16_000_000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	in_beat_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	out_beat_t            out_data;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_PUT_MODE;
	logic [31:0]          cfg_data = '0;

	int errors, pending, checked;
	int items_sent = 0;
	int phases_run = 0;
	int quiet = 0;
	bit gaps_on = 1'b1;    // clear for back-to-back stretches on both sides
	bit hold_output = 1'b0; // ask the receiver for one long hold-off

	always #10 clk = ~clk;

	binomial_american_option_pricer dut (.*);

	bao_checker chk (.*);

	// Receiver: stall a random number of cycles per beat, once a long stretch
	// that outlasts two of the largest random trees.
	initial begin
		int g;
		forever begin
			g = gaps_on ? $urandom_range(0, 7) : 0;
			if (hold_output) begin
				g = 40000;
				hold_output = 1'b0;
			end
			if (g > 0) begin
				out_stall <= 1'b1;
				repeat (g) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Watchdog: end the run if no beat moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet <= 0;
		else if (quiet >= QUIET_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end else
			quiet <= quiet + 1;
	end

	// Offer one beat, hold it until taken, then, if gaps are on, idle a random gap.
	task automatic send_option(input logic [31:0] spot, input logic [31:0] k);
		int g;
		in_data  <= '{spot_price: spot, strike: k};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		items_sent++;
		g = gaps_on ? $urandom_range(0, 7) : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_tree(input logic put, input logic [9:0] n, input logic [31:0] p,
			input logic [31:0] u, input logic [31:0] d, input logic [31:0] g,
			input logic [31:0] disc);
		write_reg(CFG_PUT_MODE, {31'd0, put});
		write_reg(CFG_STEPS_IN_USE, {22'd0, n});
		write_reg(CFG_PROB_UP, p);
		write_reg(CFG_UP_FACTOR, u);
		write_reg(CFG_DOWN_FACTOR, d);
		write_reg(CFG_LEVEL_GROWTH, g);
		write_reg(CFG_TERMINAL_DISCOUNT, disc);
		phases_run++;
	endtask

	// Drop valid and wait for every expected beat before touching registers.
	task automatic drain;
		if (in_valid) in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] near_one();
		return Q30_ONE - 32'h0100_0000 + $urandom_range(0, 32'h0200_0000);
	endfunction

	initial begin
		logic [31:0] s, k, p;
		int n;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Zero steps runs as a single level; plain call with extreme spot and strike values and one in the money.
		load_tree(1'b0, 10'd0, 32'h2000_0000, 32'h4666_6666, 32'h3A2E_8BA2, Q30_ONE, Q30_ONE);
		send_option(32'h0, 32'h0);
		send_option(32'hFFFF_FFFF, 32'h0);
		send_option(32'h0, 32'hFFFF_FFFF);
		send_option(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_option(32'd100 << 16, 32'd90 << 16);
		drain();

		// Put, probability above one, saturating up factor, zero down factor.
		load_tree(1'b1, 10'd3, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
		send_option(32'd100 << 16, 32'd110 << 16);
		send_option(32'hFFFF_FFFF, 32'h8000_0000);
		drain();
		load_tree(1'b1, 10'd4, 32'h0, 32'h4400_0000, 32'h3C00_0000, 32'h4100_0000,
			32'hFFFF_FFFF);
		send_option(32'd100 << 16, 32'd110 << 16);
		send_option(32'd50 << 16, 32'hFFFF_FFFF);
		send_option(32'hFFFF_FFFF, 32'd1);
		drain();
		load_tree(1'b0, 10'd2, Q30_ONE, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h3F00_0000);
		send_option(32'd100 << 16, 32'd95 << 16);
		send_option(32'h7FFF_FFFF, 32'h0);
		drain();

		// Deepest tree, one item only: it dominates the run time.
		load_tree(1'b1, 10'd1023, 32'h2000_0000, 32'h4008_0000, 32'h3FF8_0000,
			32'h3FFF_0000, 32'h3FF0_0000);
		send_option(32'd100 << 16, 32'd100 << 16);
		drain();

		// Random phases: mostly small trees with factors near one.
		for (int ph = 0; ph < 9; ph++) begin
			n = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			p = ($urandom_range(0, 5) == 0) ? $urandom() & 32'h7FFF_FFFF
				: $urandom_range(0, Q30_ONE);
			if ($urandom_range(0, 3) == 0)
				load_tree(1'($urandom_range(0, 1)), n[9:0], p, $urandom(), $urandom(),
					$urandom(), $urandom());
			else
				load_tree(1'($urandom_range(0, 1)), n[9:0], p, near_one(), near_one(),
					near_one(), near_one());
			gaps_on = (ph % 3) != 2;
			if (ph == 4) begin
				// Hold the output so the block fills up and stalls its input.
				gaps_on = 1'b0;
				hold_output = 1'b1;
			end
			for (int it = 0; it < 10; it++) begin
				if ($urandom_range(0, 2) == 0) begin
					s = $urandom();
					k = $urandom();
				end else begin
					s = $urandom_range(32'h0001_0000, 32'h00FF_FFFF);
					k = s + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
				end
				send_option(s, k);
			end
			drain();
			gaps_on = 1'b1;
		end

		$display("Sent %0d options over %0d register settings, %0d results compared.",
			items_sent, phases_run, checked);
		$display("Covered call and put, zero to 1023 levels, saturating factors and stalls.");
		if (errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end
endmodule
